// ===== design/hlfr_pkg.sv =====
package hlfr_pkg;

  localparam int HEADER_LEN = 8;
  localparam int LENGTH_POS = 2;
  localparam int ERROR_POS  = 1;
  localparam int NUM_DIGITS = 5;

  localparam int HDR_IDX_W = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;
  localparam int POS_W     = 17;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 16;

  localparam logic [7:0] START_BYTE  = 8'h52;
  localparam logic [7:0] COLON_BYTE  = 8'h3A;
  localparam logic [7:0] ZERO_CHAR   = 8'h30;
  localparam logic [7:0] TERM_BYTE   = 8'h00;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic [13:0] DIGIT_WEIGHT [NUM_DIGITS] = '{
    14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1
  };

  localparam int APB_AW = 3;
  localparam logic REG_BASE     = 1'b0;
  localparam logic REG_COMPRESS = 1'b1;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic              end_of_message;
    logic              header_error;
    logic [LEN_W-1:0]  message_length;
    logic              last_in_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic              compress_enable;
  } cfg_t;

endpackage

// ===== design/hlfr_ifs.sv =====
interface hlfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlfr_wr_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic        end_of_message;
  logic        header_error;
  logic [15:0] message_length;
  logic        last_in_run;

  modport source (
    output valid, output write_address, output write_data, output end_of_message,
    output header_error, output message_length, output last_in_run, input ready
  );
  modport sink (
    input valid, input write_address, input write_data, input end_of_message,
    input header_error, input message_length, input last_in_run, output ready
  );
endinterface

// ===== design/hlfr_cfg.sv =====
module hlfr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlfr_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        compress_clear,
  output hlfr_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address    <= '0;
      cfg.compress_enable <= 1'b0;
    end else begin
      if (wr_en && paddr[2] == hlfr_pkg::REG_BASE) begin
        cfg.base_address <= pwdata;
      end
      priority if (wr_en && paddr[2] == hlfr_pkg::REG_COMPRESS) begin
        cfg.compress_enable <= pwdata[0];
      end else if (compress_clear) begin
        cfg.compress_enable <= 1'b0;
      end else begin
        cfg.compress_enable <= cfg.compress_enable;
      end
    end
  end

  always_comb begin
    if (paddr[2] == hlfr_pkg::REG_COMPRESS) begin
      prdata = {31'd0, cfg.compress_enable};
    end else begin
      prdata = cfg.base_address;
    end
  end

endmodule

// ===== design/hlfr_core.sv =====
module hlfr_core (
  input  logic            clk,
  input  logic            rst,
  hlfr_rx_if.sink         rx,
  input  hlfr_pkg::cfg_t  cfg,
  input  logic            space_ok,
  output hlfr_pkg::push_t push,
  output logic            compress_clear
);

  logic                               in_valid;
  logic [7:0]                         in_byte;
  hlfr_pkg::phase_t                   phase, phase_next;
  logic [hlfr_pkg::POS_W-1:0]         position, position_next;
  logic [7:0]                         header_store [hlfr_pkg::HEADER_LEN];
  logic [hlfr_pkg::LEN_W-1:0]         decoded_length, decoded_length_next;
  logic [3:0]                         high_nibble, high_nibble_next;
  logic                               nibble_pending, nibble_pending_next;

  logic                               fire;
  logic [7:0]                         hview [hlfr_pkg::HEADER_LEN];
  logic [3:0]                         digit;
  logic [hlfr_pkg::LEN_W-1:0]         length_sum;
  logic [7:0]                         error_char;
  logic                               header_err;
  logic [hlfr_pkg::POS_W-1:0]         pos_inc;
  logic                               header_done;
  logic                               payload_end;
  logic                               data_write;
  logic [7:0]                         data_byte;
  logic                               finish;
  hlfr_pkg::result_t                  data_res;
  hlfr_pkg::result_t                  term_res;
  logic [hlfr_pkg::POS_W-1:0]         term_index;
  logic [hlfr_pkg::LEN_W-1:0]         term_length;

  assign fire     = in_valid & space_ok;
  assign rx.ready = ~in_valid | space_ok;

  always_comb begin
    for (int i = 0; i < hlfr_pkg::HEADER_LEN; i++) begin
      hview[i] = header_store[i];
      if (phase == hlfr_pkg::PH_HEADER &&
          position == hlfr_pkg::POS_W'(i)) begin
        hview[i] = in_byte;
      end
    end
  end

  always_comb begin
    length_sum = '0;
    digit      = '0;
    for (int k = 0; k < hlfr_pkg::NUM_DIGITS; k++) begin
      digit = '0;
      if (hlfr_pkg::LENGTH_POS + k < hlfr_pkg::HEADER_LEN) begin
        digit = hview[hlfr_pkg::HDR_IDX_W'(hlfr_pkg::LENGTH_POS + k)][3:0];
      end
      length_sum = length_sum + hlfr_pkg::LEN_W'(digit) *
                   hlfr_pkg::LEN_W'(hlfr_pkg::DIGIT_WEIGHT[k]);
    end
  end

  always_comb begin
    error_char = '0;
    if (hlfr_pkg::ERROR_POS < hlfr_pkg::HEADER_LEN) begin
      error_char = hview[hlfr_pkg::HDR_IDX_W'(hlfr_pkg::ERROR_POS)];
    end
    header_err = (error_char != hlfr_pkg::ZERO_CHAR);
  end

  assign pos_inc     = position + 1'b1;
  assign header_done = (pos_inc >= hlfr_pkg::POS_W'(hlfr_pkg::HEADER_LEN));
  assign payload_end = ({1'b0, pos_inc} + 1'b1) >=
                       (hlfr_pkg::POS_W + 1)'(decoded_length);

  always_comb begin
    phase_next          = phase;
    position_next       = position;
    decoded_length_next = decoded_length;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    data_write          = 1'b0;
    data_byte           = in_byte;
    finish              = 1'b0;
    term_index          = '0;
    term_length         = decoded_length;

    unique case (phase)
      hlfr_pkg::PH_HUNT: begin
        if (in_byte == hlfr_pkg::START_BYTE) begin
          phase_next    = hlfr_pkg::PH_HEADER;
          position_next = hlfr_pkg::POS_W'(1);
        end
      end
      hlfr_pkg::PH_HEADER: begin
        position_next = pos_inc;
        if (header_done) begin
          decoded_length_next = length_sum;
          term_length         = length_sum;
          phase_next          = hlfr_pkg::PH_PAYLOAD;
          position_next       = '0;
          if (length_sum <= hlfr_pkg::LEN_W'(1)) begin
            finish = 1'b1;
          end
        end
      end
      hlfr_pkg::PH_PAYLOAD: begin
        if (cfg.compress_enable) begin
          priority if (in_byte == hlfr_pkg::COLON_BYTE) begin
            data_write = 1'b1;
          end else if (!nibble_pending) begin
            high_nibble_next    = in_byte[3:0];
            nibble_pending_next = 1'b1;
          end else begin
            data_write          = 1'b1;
            data_byte           = {high_nibble, in_byte[3:0]};
            nibble_pending_next = 1'b0;
          end
        end else begin
          data_write = 1'b1;
        end
        position_next = pos_inc;
        if (payload_end) begin
          finish     = 1'b1;
          term_index = pos_inc;
        end
      end
      default: begin
        phase_next = hlfr_pkg::PH_HUNT;
      end
    endcase

    if (finish) begin
      phase_next          = hlfr_pkg::PH_HUNT;
      position_next       = '0;
      nibble_pending_next = 1'b0;
      high_nibble_next    = '0;
    end
  end

  always_comb begin
    data_res.write_address  = cfg.base_address + hlfr_pkg::ADDR_W'(position);
    data_res.write_data     = data_byte;
    data_res.end_of_message = 1'b0;
    data_res.header_error   = 1'b0;
    data_res.message_length = '0;
    data_res.last_in_run    = ~finish;

    term_res.write_address  = cfg.base_address + hlfr_pkg::ADDR_W'(term_index);
    term_res.write_data     = hlfr_pkg::TERM_BYTE;
    term_res.end_of_message = 1'b1;
    term_res.header_error   = header_err;
    term_res.message_length = term_length;
    term_res.last_in_run    = 1'b1;

    push.count  = 2'd0;
    push.first  = term_res;
    push.second = term_res;
    if (fire) begin
      if (data_write) begin
        push.first = data_res;
        push.count = finish ? 2'd2 : 2'd1;
      end else if (finish) begin
        push.count = 2'd1;
      end
    end
  end

  assign compress_clear = fire & finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      phase          <= hlfr_pkg::PH_HUNT;
      position       <= '0;
      decoded_length <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        phase          <= phase_next;
        position       <= position_next;
        decoded_length <= decoded_length_next;
        high_nibble    <= high_nibble_next;
        nibble_pending <= nibble_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
    if (fire) begin
      if (phase == hlfr_pkg::PH_HUNT && in_byte == hlfr_pkg::START_BYTE) begin
        header_store[0] <= in_byte;
      end else if (phase == hlfr_pkg::PH_HEADER &&
                   position < hlfr_pkg::POS_W'(hlfr_pkg::HEADER_LEN)) begin
        header_store[position[hlfr_pkg::HDR_IDX_W-1:0]] <= in_byte;
      end
    end
  end

endmodule

// ===== design/hlfr_out_fifo.sv =====
module hlfr_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  hlfr_pkg::push_t push,
  output logic            space_ok,
  hlfr_wr_if.source       wr
);

  hlfr_pkg::result_t                entries [hlfr_pkg::RES_DEPTH];
  logic [hlfr_pkg::RES_PTR_W-1:0]   wr_ptr;
  logic [hlfr_pkg::RES_PTR_W-1:0]   rd_ptr;
  logic [hlfr_pkg::RES_CNT_W-1:0]   count, count_next;
  logic                             pop;
  hlfr_pkg::result_t                head;

  assign pop      = wr.valid & wr.ready;
  assign space_ok = count <= hlfr_pkg::RES_CNT_W'(hlfr_pkg::RES_DEPTH - 2);
  assign count_next = count + hlfr_pkg::RES_CNT_W'(push.count)
                    - hlfr_pkg::RES_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + hlfr_pkg::RES_PTR_W'(push.count);
      rd_ptr <= rd_ptr + hlfr_pkg::RES_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  assign head              = entries[rd_ptr];
  assign wr.valid          = (count != '0);
  assign wr.write_address  = head.write_address;
  assign wr.write_data     = head.write_data;
  assign wr.end_of_message = head.end_of_message;
  assign wr.header_error   = head.header_error;
  assign wr.message_length = head.message_length;
  assign wr.last_in_run    = head.last_in_run;

endmodule

// ===== design/header_length_framed_byte_receiver.sv =====
// Channel  Kind            Direction  Transaction
// rx       valid/ready     in         one received byte
// wr       valid/ready     out        one RAM byte write
// apb      psel/penable    in         register write or read
//
// The input register takes a new byte every cycle while the result queue has
// room for two writes; each byte is decoded from the input register into the
// queue; a byte that ends a message can queue two writes, data and terminator.
// Reset is synchronous and returns the receiver to hunting for the start byte.
// A write stall leaves under two of the four queue entries free and holds rx.
module header_length_framed_byte_receiver (
  input  logic                        clk,
  input  logic                        rst,
  hlfr_rx_if.sink                     rx,
  hlfr_wr_if.source                   wr,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlfr_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  hlfr_pkg::cfg_t  cfg;
  hlfr_pkg::push_t push;
  logic            compress_clear;
  logic            space_ok;

  hlfr_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .compress_clear (compress_clear),
    .cfg            (cfg)
  );

  hlfr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .cfg            (cfg),
    .space_ok       (space_ok),
    .push           (push),
    .compress_clear (compress_clear)
  );

  hlfr_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .wr       (wr)
  );

endmodule
